[hw/rtl/nvd_pkg.sv]
// ----------------------------------------------------------------------------
// nvd_pkg
// Shared types and constants for the nibble varint decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nvd_pkg;

   // pending nested count codes allowed before the error
   localparam int unsigned MAX_NEST = 15;
   localparam int unsigned DEPTH_W  = $clog2(MAX_NEST + 1);

   localparam int unsigned NIB_W    = 4;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned LEN_W    = 6;

   // lead nibble codes
   localparam logic [NIB_W-1:0] NIB_SHORT_MAX = 4'h6;
   localparam logic [NIB_W-1:0] NIB_NEST      = 4'h7;
   localparam logic [NIB_W-1:0] NIB_LEN6_MAX  = 4'hb;
   localparam logic [NIB_W-1:0] NIB_LEN9_MAX  = 4'hd;
   localparam logic [NIB_W-1:0] NIB_LEN12     = 4'he;

   // largest legal payload count in nibbles
   localparam logic [VALUE_W-1:0] MAX_COUNT = 32'd8;

   localparam logic [LEN_W-1:0] LEN_SHORT = 6'd3;
   localparam logic [LEN_W-1:0] LEN_6     = 6'd6;
   localparam logic [LEN_W-1:0] LEN_9     = 6'd9;
   localparam logic [LEN_W-1:0] LEN_12    = 6'd12;

   typedef struct packed {
      logic [NIB_W-1:0] nibble;
      logic             want_signed;
   } item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   bit_length;
      logic               length_error;
      logic               is_signed;
   } rslt_type;

endpackage

`default_nettype wire

[hw/rtl/nvd_in_stage.sv]
// ----------------------------------------------------------------------------
// nvd_in_stage
// Input register for nibble transfers, released when the decoder takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module nvd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire nvd_pkg::item_type req_item,
   input  wire logic              take,
   output logic                   item_valid,
   output nvd_pkg::item_type      item
);

   logic              valid_ff, valid_in;
   nvd_pkg::item_type item_ff;
   logic              load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[hw/rtl/nvd_decode_core.sv]
// ----------------------------------------------------------------------------
// nvd_decode_core
// Code state machine: one nibble per cycle updates phase, payload accumulator
// and nesting depth, and flags a finished outermost code, held until out_free.
// ----------------------------------------------------------------------------
`default_nettype none

module nvd_decode_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire nvd_pkg::item_type item,
   input  wire logic              out_free,
   output logic                   take,
   output logic                   emit,
   output nvd_pkg::rslt_type      rslt
);

   typedef enum logic [1:0] {PH_START, PH_LEAD, PH_PAYLOAD} phase_type;

   phase_type                        phase_ff, phase_in;
   logic [3:0]                       left_ff, left_in;
   logic [nvd_pkg::VALUE_W-1:0]      accum_ff, accum_in;
   logic [nvd_pkg::DEPTH_W-1:0]      depth_ff, depth_in;
   logic                             signed_ff, signed_in;
   logic                             err_ff, err_in;
   logic [nvd_pkg::LEN_W-1:0]        codelen_ff, codelen_in;

   logic                             comp;
   logic [nvd_pkg::VALUE_W-1:0]      cv;
   logic [nvd_pkg::LEN_W-1:0]        clen;
   logic [nvd_pkg::VALUE_W-1:0]      acc_shift;
   logic [3:0]                       left_dec;
   logic [nvd_pkg::NIB_W-1:0]        nib;
   logic                             bad_count;

   assign nib       = item.nibble;
   assign acc_shift = {accum_ff[nvd_pkg::VALUE_W-nvd_pkg::NIB_W-1:0], nib};
   assign left_dec  = left_ff - 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      accum_in   = accum_ff;
      depth_in   = depth_ff;
      signed_in  = signed_ff;
      err_in     = err_ff;
      codelen_in = codelen_ff;
      comp       = 1'b0;
      cv         = '0;
      clen       = '0;
      emit       = 1'b0;
      bad_count  = 1'b0;
      rslt       = '0;

      case (phase_ff)
         PH_PAYLOAD: begin
            if (left_dec == 4'd0) begin
               comp = 1'b1;
               cv   = acc_shift;
               clen = codelen_ff;
            end else begin
               accum_in = acc_shift;
               left_in  = left_dec;
            end
         end
         PH_START, PH_LEAD: begin
            if (phase_ff == PH_START) begin
               signed_in = item.want_signed;
            end
            if (nib <= nvd_pkg::NIB_SHORT_MAX) begin
               comp = 1'b1;
               cv   = {{(nvd_pkg::VALUE_W-3){1'b0}}, nib[2:0]};
               clen = nvd_pkg::LEN_SHORT;
            end else if (nib == nvd_pkg::NIB_NEST) begin
               if (depth_ff >= nvd_pkg::DEPTH_W'(nvd_pkg::MAX_NEST)) begin
                  err_in = 1'b1;
                  comp   = 1'b1;
               end else begin
                  depth_in = depth_ff + nvd_pkg::DEPTH_W'(1);
                  phase_in = PH_LEAD;
               end
            end else if (nib <= nvd_pkg::NIB_LEN6_MAX) begin
               accum_in   = {{(nvd_pkg::VALUE_W-2){1'b0}}, nib[1:0]};
               left_in    = 4'd1;
               codelen_in = nvd_pkg::LEN_6;
               phase_in   = PH_PAYLOAD;
            end else if (nib <= nvd_pkg::NIB_LEN9_MAX) begin
               accum_in   = {{(nvd_pkg::VALUE_W-1){1'b0}}, nib[0]};
               left_in    = 4'd2;
               codelen_in = nvd_pkg::LEN_9;
               phase_in   = PH_PAYLOAD;
            end else if (nib == nvd_pkg::NIB_LEN12) begin
               accum_in   = '0;
               left_in    = 4'd3;
               codelen_in = nvd_pkg::LEN_12;
               phase_in   = PH_PAYLOAD;
            end else begin
               // prefix nibble, skipped
               phase_in = PH_LEAD;
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase

      if (comp) begin
         bad_count = cv > nvd_pkg::MAX_COUNT;
         if (depth_ff == '0) begin
            emit = 1'b1;
         end else if (bad_count || cv == '0) begin
            // a bad or empty count unwinds every pending level to an empty code
            err_in   = err_in || bad_count;
            depth_in = '0;
            cv       = '0;
            clen     = '0;
            emit     = 1'b1;
         end else begin
            depth_in   = depth_ff - nvd_pkg::DEPTH_W'(1);
            left_in    = cv[3:0];
            accum_in   = '0;
            codelen_in = {cv[3:0], 2'b00};
            phase_in   = PH_PAYLOAD;
         end
         if (emit) begin
            phase_in   = PH_START;
            left_in    = 4'd0;
            accum_in   = '0;
            codelen_in = clen;
         end
      end

      rslt.value        = cv;
      rslt.bit_length   = clen;
      rslt.length_error = err_in;
      rslt.is_signed    = signed_in;
   end

   assign take = item_valid && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         left_ff    <= 4'd0;
         accum_ff   <= '0;
         depth_ff   <= '0;
         signed_ff  <= 1'b0;
         err_ff     <= 1'b0;
         codelen_ff <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         accum_ff   <= accum_in;
         depth_ff   <= depth_in;
         signed_ff  <= signed_in;
         err_ff     <= err_in;
         codelen_ff <= codelen_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/nvd_out_stage.sv]
// ----------------------------------------------------------------------------
// nvd_out_stage
// Sign extension of a finished code and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nvd_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire nvd_pkg::rslt_type rslt,
   output logic                   out_free,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [39:0]            rsp_tdata
);

   logic                             valid_ff, valid_in;
   logic [nvd_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic [nvd_pkg::LEN_W-1:0]        len_ff;
   logic                             err_ff;
   logic [4:0]                       sign_idx;
   logic [nvd_pkg::VALUE_W-1:0]      high_mask;

   assign sign_idx  = rslt.bit_length[4:0] - 5'd1;
   assign high_mask = {nvd_pkg::VALUE_W{1'b1}} << rslt.bit_length;

   always_comb begin
      value_in = rslt.value;
      // lengths 1 to 31 are extended; empty and full-width codes stay as is
      if (rslt.is_signed && rslt.bit_length != '0 && !rslt.bit_length[5]
          && rslt.value[sign_idx]) begin
         value_in = rslt.value | high_mask;
      end
   end

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         value_ff <= value_in;
         len_ff   <= rslt.bit_length;
         err_ff   <= rslt.length_error;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, err_ff, len_ff, value_ff};

endmodule

`default_nettype wire

[hw/rtl/nibble_varint_decoder.sv]
// ----------------------------------------------------------------------------
// nibble_varint_decoder
// Decodes variable-length integer codes from a stream of 4-bit nibbles.
// ----------------------------------------------------------------------------
// One nibble arrives per req_ transfer, high nibble first. When a nibble
// finishes an outermost code (nested count codes included), one rsp_
// transfer carries the decoded value, its bit length and the sticky error
// flag; every other nibble gives no result.
// A nibble that finishes its code passes the input register, and its result
// the result register, before rsp_tvalid rises.
// Throughput: one nibble per cycle unless the receiver stalls; the
// state update and the sign extension sit in one combinational pass
// between the two registers.
// When the receiver stalls, the result register holds its result and the
// input register keeps taking nibbles that finish no code; a nibble that
// would finish one waits in the input register, and req_tready drops.
// Reset clears the code state, the nesting depth and the sticky error,
// and empties both registers. The error flag is cleared only by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_varint_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // nibble[3:0], want_signed[4], zero[7:5]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // value[31:0], bit_length[37:32],
                                         // length_error[38], zero[39]
);

   nvd_pkg::item_type req_item;
   nvd_pkg::item_type item;
   nvd_pkg::rslt_type rslt;
   logic              item_valid;
   logic              take;
   logic              emit;
   logic              out_free;

   assign req_item.nibble      = req_tdata[3:0];
   assign req_item.want_signed = req_tdata[4];

   nvd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   nvd_decode_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .emit       (emit),
      .rslt       (rslt)
   );

   nvd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && emit),
      .rslt       (rslt),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[hw/rtl/nvd_checker.sv]
// ----------------------------------------------------------------------------
// nvd_checker
// Port-level checks for the nibble varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nvd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   logic err_seen_ff;
   logic rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // error flag once reported stays reported
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_xfer && rsp_tdata[38]) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && err_seen_ff |-> rsp_tdata[38])
      else $error("length error flag dropped");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37:32] == 6'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("empty code with nonzero value");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:32] <= 6'd32 && !rsp_tdata[39])
      else $error("bit length out of range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind nibble_varint_decoder nvd_checker u_nvd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
